// ----- rtl/ert_pkg.sv -----
`timescale 1ns / 1ps

package ert_pkg;

  // Fixed constants of the estimator.
  localparam int SMOOTH_DIV = 3;
  localparam int GAIN_FAST  = 3;
  localparam int GAIN_SLOW  = 9;
  localparam int VAR_MULT   = 3;
  localparam int RTO_MARGIN = 2;

endpackage

// ----- rtl/ert_cdiv.sv -----
`timescale 1ns / 1ps

module ert_cdiv #(
  parameter int W       = 26,
  parameter int DIVISOR = 3
) (
  input  logic [W-1:0] num,
  output logic [W-1:0] quot
);

  localparam int DW = $clog2(DIVISOR + 1);
  localparam int RW = W + DW;
  localparam logic [W-1:0]  RECIP = W'((64'd1 << W) / DIVISOR);
  localparam logic [DW-1:0] DIV_C = DW'(DIVISOR);

  logic [2*W-1:0] prod;
  logic [W-1:0]   q0;
  logic [RW-1:0]  back;
  logic [RW-1:0]  rem;

  // The truncated reciprocal gives a quotient that is exact or one low, so a
  // single remainder compare corrects it.
  always_comb begin
    prod = (2*W)'(num) * (2*W)'(RECIP);
    q0   = prod[2*W-1:W];
    back = RW'(q0) * RW'(DIV_C);
    rem  = RW'(num) - back;
    quot = (rem >= RW'(DIV_C)) ? q0 + W'(1) : q0;
  end

endmodule

// ----- rtl/ert_update.sv -----
`timescale 1ns / 1ps

module ert_update
  import ert_pkg::*;
#(
  parameter int TICK_WIDTH = 24
) (
  input  logic [TICK_WIDTH-1:0] rtt,
  input  logic [TICK_WIDTH+1:0] smoothed_mag,
  input  logic                  smoothed_pos,
  input  logic [TICK_WIDTH+1:0] var_mag,
  input  logic                  var_pos,
  output logic [TICK_WIDTH+1:0] smoothed_mag_upd,
  output logic                  smoothed_pos_upd,
  output logic [TICK_WIDTH+1:0] var_mag_upd,
  output logic                  var_pos_upd
);

  localparam int MW = TICK_WIDTH + 2;
  localparam int DW = MW + 1;
  localparam int XW = MW + 2;

  logic [DW-1:0] rtt_d;
  logic [DW-1:0] s_d;
  logic [DW-1:0] delta;
  logic          delta_pos;
  logic [DW-1:0] delta_3;
  logic [DW-1:0] s_w;
  logic          gain_fast;
  logic [XW-1:0] x;
  logic [XW-1:0] x_3;
  logic [XW-1:0] x_9;
  logic [XW-1:0] q;
  logic [XW-1:0] v_x;
  logic [XW-1:0] v_w;
  logic          vp_w;

  assign rtt_d = DW'(rtt);
  assign s_d   = DW'(smoothed_mag);
  assign v_x   = XW'(var_mag);

  ert_cdiv #(.W(DW), .DIVISOR(SMOOTH_DIV)) u_div_delta (.num(delta), .quot(delta_3));
  ert_cdiv #(.W(XW), .DIVISOR(GAIN_FAST))  u_div_fast  (.num(x),     .quot(x_3));
  ert_cdiv #(.W(XW), .DIVISOR(GAIN_SLOW))  u_div_slow  (.num(x),     .quot(x_9));

  always_comb begin
    // Signed difference between sample and smoothed value.
    if (smoothed_pos) begin
      if (rtt_d >= s_d) begin
        delta     = rtt_d - s_d;
        delta_pos = 1'b1;
      end else begin
        delta     = s_d - rtt_d;
        delta_pos = 1'b0;
      end
    end else begin
      delta     = rtt_d + s_d;
      delta_pos = 1'b1;
    end

    if (delta_pos) begin
      gain_fast = !var_pos || (delta >= DW'(var_mag));
    end else begin
      gain_fast = !(var_pos || (DW'(var_mag) < delta));
    end

    // Smoothed value moves by a third of the delta.
    smoothed_pos_upd = smoothed_pos;
    if (smoothed_pos == delta_pos) begin
      s_w = s_d + delta_3;
    end else if (s_d >= delta_3) begin
      s_w = s_d - delta_3;
    end else begin
      s_w              = delta_3 - s_d;
      smoothed_pos_upd = !smoothed_pos;
    end
    smoothed_mag_upd = s_w[DW-1] ? {MW{1'b1}} : s_w[MW-1:0];

    // Numerator of the variation step for each sign case.
    if (!var_pos) begin
      x = XW'(delta) + v_x;
    end else if (delta >= DW'(var_mag)) begin
      x = XW'(delta) - v_x;
    end else begin
      x = v_x - XW'(delta);
    end
    q = gain_fast ? x_3 : x_9;

    vp_w = var_pos;
    if (var_pos) begin
      if (delta >= DW'(var_mag)) begin
        v_w = v_x + q;
      end else if (v_x >= q) begin
        v_w = v_x - q;
      end else begin
        v_w  = q - v_x;
        vp_w = 1'b0;
      end
    end else if (v_x <= q) begin
      v_w  = q - v_x;
      vp_w = 1'b1;
    end else begin
      v_w = v_x - q;
    end

    // A negative delta leaves the variation alone.
    if (delta_pos) begin
      var_mag_upd = (|v_w[XW-1:MW]) ? {MW{1'b1}} : v_w[MW-1:0];
      var_pos_upd = vp_w;
    end else begin
      var_mag_upd = var_mag;
      var_pos_upd = var_pos;
    end
  end

endmodule

// ----- rtl/ert_timeout.sv -----
`timescale 1ns / 1ps

module ert_timeout
  import ert_pkg::*;
#(
  parameter int TICK_WIDTH = 24
) (
  input  logic [TICK_WIDTH-1:0] rtt,
  input  logic [TICK_WIDTH+1:0] smoothed_mag,
  input  logic                  smoothed_pos,
  input  logic [TICK_WIDTH+1:0] var_mag,
  input  logic                  var_pos,
  output logic [TICK_WIDTH+1:0] rto
);

  localparam int MW = TICK_WIDTH + 2;
  localparam int SW = MW + 2;

  logic [SW-1:0] s_x;
  logic [SW-1:0] v3;
  logic [SW-1:0] floor_val;
  logic [SW-1:0] sum;
  logic [SW-1:0] rto_w;

  always_comb begin
    s_x       = SW'(smoothed_mag);
    v3        = SW'(var_mag) * SW'(VAR_MULT);
    floor_val = SW'(rtt) + SW'(RTO_MARGIN);
    sum       = '0;
    rto_w     = floor_val;
    // Every sign case that would come out negative falls back to the floor.
    if (smoothed_pos && var_pos) begin
      sum   = s_x + v3;
      rto_w = (floor_val > sum) ? floor_val : sum;
    end else if (smoothed_pos) begin
      if (s_x >= v3) begin
        sum   = s_x - v3;
        rto_w = (floor_val > sum) ? floor_val : sum;
      end
    end else if (var_pos) begin
      if (v3 >= s_x) begin
        sum   = v3 - s_x;
        rto_w = (sum >= floor_val) ? sum : floor_val;
      end
    end
    rto = (|rto_w[SW-1:MW]) ? {MW{1'b1}} : rto_w[MW-1:0];
  end

endmodule

// ----- rtl/eifel_rto_estimator.sv -----
`timescale 1ns / 1ps

// Retransmission timeout estimator: each RTT sample on the input channel
// yields one timeout on the output channel, in order. The block takes a new
// sample every cycle while the output is not stalled; out_valid rises once the
// sample has passed the input register, the state update and the result
// register. The sustained rate is set by the state update: the delta, the
// divide-by-3 and divide-by-9 reciprocal multiplies and the saturating adds
// close combinationally on the smoothed and variation registers. Reset clears the
// state at once; there is no clearing pass. Stalls on the output back up
// through the stages without losing or repeating a transaction.
module eifel_rto_estimator
  import ert_pkg::*;
#(
  parameter int TICK_WIDTH = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [TICK_WIDTH-1:0] in_rtt_sample,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [TICK_WIDTH+1:0] out_rto_ticks
);

  localparam int MW = TICK_WIDTH + 2;

  logic                  v1_r;
  logic                  v2_r;
  logic                  out_valid_r;
  logic [TICK_WIDTH-1:0] rtt1_r;
  logic [TICK_WIDTH-1:0] rtt2_r;
  logic [MW-1:0]         out_rto_r;

  logic [MW-1:0]         smoothed_mag_r;
  logic                  smoothed_pos_r;
  logic [MW-1:0]         var_mag_r;
  logic                  var_pos_r;
  logic [MW-1:0]         smoothed_mag_nxt;
  logic                  smoothed_pos_nxt;
  logic [MW-1:0]         var_mag_nxt;
  logic                  var_pos_nxt;
  logic [MW-1:0]         rto;

  logic                  ld1;
  logic                  ld2;
  logic                  ld3;

  assign ld3      = v2_r && (!out_valid_r || out_ready);
  assign ld2      = v1_r && (!v2_r || ld3);
  assign in_ready = !v1_r || ld2;
  assign ld1      = in_valid && in_ready;

  assign out_valid     = out_valid_r;
  assign out_rto_ticks = out_rto_r;

  ert_update #(.TICK_WIDTH(TICK_WIDTH)) u_update (
    .rtt              (rtt1_r),
    .smoothed_mag     (smoothed_mag_r),
    .smoothed_pos     (smoothed_pos_r),
    .var_mag          (var_mag_r),
    .var_pos          (var_pos_r),
    .smoothed_mag_upd (smoothed_mag_nxt),
    .smoothed_pos_upd (smoothed_pos_nxt),
    .var_mag_upd      (var_mag_nxt),
    .var_pos_upd      (var_pos_nxt)
  );

  // The state only changes when stage two loads, so while stage two holds a
  // sample the state registers are exactly the state that sample left.
  ert_timeout #(.TICK_WIDTH(TICK_WIDTH)) u_timeout (
    .rtt          (rtt2_r),
    .smoothed_mag (smoothed_mag_r),
    .smoothed_pos (smoothed_pos_r),
    .var_mag      (var_mag_r),
    .var_pos      (var_pos_r),
    .rto          (rto)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r           <= 1'b0;
      v2_r           <= 1'b0;
      out_valid_r    <= 1'b0;
      smoothed_mag_r <= '0;
      smoothed_pos_r <= 1'b1;
      var_mag_r      <= '0;
      var_pos_r      <= 1'b1;
    end else begin
      if (ld1) begin
        v1_r <= 1'b1;
      end else if (ld2) begin
        v1_r <= 1'b0;
      end
      if (ld2) begin
        v2_r           <= 1'b1;
        smoothed_mag_r <= smoothed_mag_nxt;
        smoothed_pos_r <= smoothed_pos_nxt;
        var_mag_r      <= var_mag_nxt;
        var_pos_r      <= var_pos_nxt;
      end else if (ld3) begin
        v2_r <= 1'b0;
      end
      if (ld3) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      rtt1_r <= in_rtt_sample;
    end
    if (ld2) begin
      rtt2_r <= rtt1_r;
    end
    if (ld3) begin
      out_rto_r <= rto;
    end
  end

  // The timeout never drops below the sample plus the margin; this check holds it to the margin alone.
  a_rto_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_rto_r >= MW'(RTO_MARGIN)))
    else $error("timeout below margin");

  a_reset_state: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> (smoothed_pos_r && var_pos_r && smoothed_mag_r == '0 &&
                       var_mag_r == '0))
    else $error("state not cleared by reset");

  a_stage2_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !v2_r) |-> ld2)
    else $error("empty update stage did not take waiting sample");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !ld3) |=> (v2_r && $stable(smoothed_mag_r) && $stable(var_mag_r) &&
                        $stable(smoothed_pos_r) && $stable(var_pos_r)))
    else $error("state changed while its timeout was pending");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import ert_pkg::*;

  localparam int TICK_W = 24;
  localparam int MAG_W = TICK_W + 2;
  localparam logic [63:0] MAG_MAX = (64'd1 << MAG_W) - 64'd1;
  localparam logic [TICK_W-1:0] SAMPLE_MAX = {TICK_W{1'b1}};
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [TICK_W-1:0] in_rtt_sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [MAG_W-1:0] out_rto_ticks;

  // Estimator state tracked alongside the block.
  logic [MAG_W-1:0] smooth_mag;
  logic smooth_pos;
  logic [MAG_W-1:0] var_mag;
  logic var_pos;

  logic [MAG_W-1:0] rto_expected_q[$];
  int mismatch_count = 0;
  int stall_cycles = 0;
  bit idle_on = 1'b1;

  eifel_rto_estimator #(
    .TICK_WIDTH(TICK_W)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_rtt_sample(in_rtt_sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_rto_ticks(out_rto_ticks)
  );

  always #6 clk = ~clk;

  function automatic logic [63:0] clamp_mag(input logic [63:0] v);
    return (v > MAG_MAX) ? MAG_MAX : v;
  endfunction

  // Advances the tracked estimator by one sample and returns the new timeout.
  function automatic logic [MAG_W-1:0] predict_rto(input logic [TICK_W-1:0] sample);
    logic [63:0] r, s, v, d, d3, g, q, floor_ticks, sum, rto;
    logic sp, vp, dp;
    r = 64'(sample);
    s = 64'(smooth_mag);
    v = 64'(var_mag);
    sp = smooth_pos;
    vp = var_pos;

    if (sp) begin
      if (r >= s) begin
        d = r - s;
        dp = 1'b1;
      end else begin
        d = s - r;
        dp = 1'b0;
      end
    end else begin
      d = r + s;
      dp = 1'b1;
    end

    if (dp) begin
      g = (!vp || d >= v) ? 64'(GAIN_FAST) : 64'(GAIN_SLOW);
    end else begin
      g = (vp || v < d) ? 64'(GAIN_SLOW) : 64'(GAIN_FAST);
    end

    d3 = d / 64'(SMOOTH_DIV);
    if (sp == dp) begin
      s = s + d3;
    end else if (s >= d3) begin
      s = s - d3;
    end else begin
      s = d3 - s;
      sp = ~sp;
    end
    smooth_mag = MAG_W'(clamp_mag(s));
    smooth_pos = sp;

    // The variation only follows a non-negative delta.
    if (dp) begin
      if (vp) begin
        if (d >= v) begin
          v = v + (d - v) / g;
        end else begin
          q = (v - d) / g;
          if (v >= q) begin
            v = v - q;
          end else begin
            v = q - v;
            vp = 1'b0;
          end
        end
      end else begin
        q = (d + v) / g;
        if (v <= q) begin
          v = q - v;
          vp = 1'b1;
        end else begin
          v = v - q;
        end
      end
      var_mag = MAG_W'(clamp_mag(v));
      var_pos = vp;
    end

    s = 64'(smooth_mag);
    v = 64'(var_mag) * 64'(VAR_MULT);
    floor_ticks = r + 64'(RTO_MARGIN);
    rto = floor_ticks;
    if (sp && vp) begin
      sum = s + v;
      rto = (floor_ticks > sum) ? floor_ticks : sum;
    end else if (sp) begin
      if (s >= v) begin
        sum = s - v;
        rto = (floor_ticks > sum) ? floor_ticks : sum;
      end
    end else if (vp) begin
      if (v >= s) begin
        sum = v - s;
        rto = (sum >= floor_ticks) ? sum : floor_ticks;
      end
    end
    return MAG_W'(clamp_mag(rto));
  endfunction

  task automatic send_sample(input logic [TICK_W-1:0] sample);
    int gap;
    gap = (idle_on && $urandom_range(99) < 17) ? int'($urandom_range(4, 1)) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rtt_sample <= sample;
    do @(posedge clk); while (!in_ready);
    rto_expected_q.push_back(predict_rto(sample));
  endtask

  // Picks a sample near base, spread by up to span either way.
  function automatic logic [TICK_W-1:0] jitter_sample(input int base, input int span);
    int x;
    x = base + int'($urandom_range(2 * span)) - span;
    if (x < 0) x = 0;
    if (x > int'(SAMPLE_MAX)) x = int'(SAMPLE_MAX);
    return TICK_W'(x);
  endfunction

  task automatic test_directed();
    send_sample('0);
    send_sample('0);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);
    // Large negative delta: the smoothed value drops while the variation holds.
    send_sample('0);
    send_sample(TICK_W'(1));
    send_sample(TICK_W'(2));
    send_sample(TICK_W'(3));
    // Swinging between the extremes drives the variation term up.
    repeat (4) begin
      send_sample(SAMPLE_MAX);
      send_sample('0);
    end
    // A steady low sample pulls the smoothed value down while the variation holds.
    repeat (4) send_sample(TICK_W'(100));
    send_sample(SAMPLE_MAX - TICK_W'(1));
    send_sample(TICK_W'(24'h800000));
    send_sample(TICK_W'(24'h555555));
    send_sample(TICK_W'(24'hAAAAAA));
  endtask

  task automatic test_random_walk(input int count);
    int base;
    int span;
    base = int'($urandom_range(5000));
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 3) begin
        base = ($urandom_range(3) == 0) ? int'($urandom_range(int'(SAMPLE_MAX)))
                                        : int'($urandom_range(50000));
      end
      span = base / 4 + 3;
      if ($urandom_range(99) < 5) begin
        send_sample(jitter_sample(base * 4 + 10, span));
      end else begin
        send_sample(jitter_sample(base, span));
      end
    end
  endtask

  task automatic test_full_range(input int count);
    for (int i = 0; i < count; i++) begin
      send_sample(TICK_W'($urandom));
    end
  endtask

  task automatic test_extremes(input int count);
    logic [TICK_W-1:0] sample;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(3))
        0: sample = '0;
        1: sample = SAMPLE_MAX - TICK_W'($urandom_range(3));
        2: sample = TICK_W'($urandom_range(15));
        default: sample = TICK_W'($urandom);
      endcase
      send_sample(sample);
    end
  endtask

  task automatic test_back_to_back(input int count);
    idle_on = 1'b0;
    test_random_walk(count / 2);
    test_full_range(count - count / 2);
    idle_on = 1'b1;
  endtask

  always @(posedge clk) begin
    if (!idle_on) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 30);
    end
  end

  always @(posedge clk) begin
    logic [MAG_W-1:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (rto_expected_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("unexpected result: rto_ticks=%0d", out_rto_ticks);
        end
      end else begin
        want = rto_expected_q.pop_front();
        if (out_rto_ticks !== want) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("rto_ticks mismatch: expected %0d, got %0d", want, out_rto_ticks);
          end
        end
      end
    end
  end

  // Ends the run if neither channel completes a transaction for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    smooth_mag = '0;
    smooth_pos = 1'b1;
    var_mag = '0;
    var_pos = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_walk(700);
    test_full_range(300);
    test_extremes(300);
    test_back_to_back(300);
    test_random_walk(200);

    in_valid <= 1'b0;
    while (rto_expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatch_count == 0 && rto_expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
